[src/point_grid_bin_and_colour_core_macros.svh]
// ----------------------------------------------------------------------------
// point grid bin and colour: assertion macros
// concurrent checks clocked on clk and held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef POINT_GRID_BIN_AND_COLOUR_CORE_MACROS_SVH
`define POINT_GRID_BIN_AND_COLOUR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PGB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pgb assertion failed");
// next-cycle implication
`define PGB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pgb assertion failed");
`else
`define PGB_ASSERT_IMP(lbl, ante, cons)
`define PGB_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[src/pgb_pkg.sv]
// ----------------------------------------------------------------------------
// pgb_pkg
// shared constants, types and the class palette of the grid binning core
// ----------------------------------------------------------------------------
`default_nettype none

package pgb_pkg;

  localparam int MAX_GRID_DEF    = 32;
  localparam int PALETTE_ENTRIES = 16;
  localparam int PAL_TABLE_SIZE  = 16;
  localparam int POS_W           = 32;
  localparam int CELL_W          = 15;

  // register indexes on the config port
  localparam logic [2:0] REG_MIN_X   = 3'd0;
  localparam logic [2:0] REG_MIN_Y   = 3'd1;
  localparam logic [2:0] REG_MIN_Z   = 3'd2;
  localparam logic [2:0] REG_SCALE_X = 3'd3;
  localparam logic [2:0] REG_SCALE_Y = 3'd4;
  localparam logic [2:0] REG_SCALE_Z = 3'd5;
  localparam logic [2:0] REG_GRID    = 3'd6;
  localparam logic [2:0] REG_MODE    = 3'd7;

  // colour modes
  localparam logic [1:0] MODE_AUTO  = 2'd0;
  localparam logic [1:0] MODE_RGB   = 2'd1;
  localparam logic [1:0] MODE_GREY  = 2'd2;
  localparam logic [1:0] MODE_CLASS = 2'd3;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // per-point data that rides alongside the axis units
  typedef struct packed {
    logic [31:0] index;
    rgb_t        colour;
  } meta_t;

  // one axis worth of operands
  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic signed [POS_W-1:0] minv;
    logic        [POS_W-1:0] scale;
  } axis_op_t;

  localparam rgb_t WHITE = '{r: 8'd255, g: 8'd255, b: 8'd255};

  // palette fractions rounded to 8 bits
  function automatic rgb_t palette_rgb(input logic [3:0] cls);
    rgb_t c;
    case (cls)
      4'd0:    c = '{r: 8'd128, g: 8'd128, b: 8'd128};
      4'd1:    c = '{r: 8'd179, g: 8'd179, b: 8'd179};
      4'd2:    c = '{r: 8'd153, g: 8'd102, b: 8'd51};
      4'd3:    c = '{r: 8'd140, g: 8'd204, b: 8'd77};
      4'd4:    c = '{r: 8'd64,  g: 8'd166, b: 8'd26};
      4'd5:    c = '{r: 8'd0,   g: 8'd115, b: 8'd13};
      4'd6:    c = '{r: 8'd230, g: 8'd191, b: 8'd26};
      4'd7:    c = '{r: 8'd204, g: 8'd26,  b: 8'd26};
      4'd8:    c = '{r: 8'd77,  g: 8'd77,  b: 8'd230};
      4'd9:    c = '{r: 8'd0,   g: 8'd140, b: 8'd255};
      4'd10:   c = '{r: 8'd217, g: 8'd217, b: 8'd217};
      4'd11:   c = '{r: 8'd242, g: 8'd140, b: 8'd38};
      4'd12:   c = '{r: 8'd179, g: 8'd0,   b: 8'd179};
      4'd13:   c = '{r: 8'd255, g: 8'd51,  b: 8'd204};
      4'd14:   c = '{r: 8'd255, g: 8'd153, b: 8'd0};
      4'd15:   c = '{r: 8'd0,   g: 8'd230, b: 8'd230};
      default: c = WHITE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[src/pgb_axis.sv]
// ----------------------------------------------------------------------------
// pgb_axis
// three-stage cell coordinate for one axis: subtract, multiply, clamp
// ----------------------------------------------------------------------------
`default_nettype none

module pgb_axis #(
  parameter int GW = 6
) (
  input  wire logic              clk,
  input  wire pgb_pkg::axis_op_t op,
  input  wire logic [GW-1:0]     gm1,
  output logic      [GW-1:0]     coord
);

  logic [32:0] diff;
  logic        pos_r;
  logic [31:0] mag_r;
  logic [63:0] prod;
  logic [31:0] hi_r;
  logic [GW-1:0] coord_r;

  // exact 33-bit difference
  assign diff = {op.pos[31], op.pos} - {op.minv[31], op.minv};

  always_ff @(posedge clk) begin
    pos_r <= !diff[32] && (diff != 33'd0);
    mag_r <= diff[31:0];
  end

  // integer part of the Q32.32 product
  assign prod = {32'd0, mag_r} * {32'd0, op.scale};

  always_ff @(posedge clk) begin
    hi_r <= pos_r ? prod[63:32] : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (hi_r > 32'(gm1)) begin
      coord_r <= gm1;
    end else begin
      coord_r <= hi_r[GW-1:0];
    end
  end

  assign coord = coord_r;

endmodule

`default_nettype wire

[src/point_grid_bin_and_colour_core.sv]
// ----------------------------------------------------------------------------
// point_grid_bin_and_colour_core
// bins a point into a cubic grid cell and picks its display colour
// ----------------------------------------------------------------------------
// usage:
//   input beat: a point is taken at a rising edge with start high and busy low;
//   in_keep low drops the point, it gives no result beat
//   result beat: out_valid is high for exactly one cycle with out_index,
//   out_cell_index and the chosen colour; the receiver cannot stall, so
//   nothing waits and nothing backs up
//   pipe: five stages (subtract, 32x32 multiply, clamp, y+g*z, x+g*t);
//   throughput one point per cycle while busy is low
//   config: cfg_we writes register cfg_index with cfg_data; the user
//   must write only while no point is in flight, the block does not
//   enforce it
//   reset: synchronous rst_n clears the pipe valid bits and loads the
//   register defaults; busy is high for the cycle after a reset edge
// ----------------------------------------------------------------------------
`default_nettype none

module point_grid_bin_and_colour_core #(
  parameter int MAX_GRID = pgb_pkg::MAX_GRID_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_point_index,
  input  wire logic [31:0] in_pos_x,
  input  wire logic [31:0] in_pos_y,
  input  wire logic [31:0] in_pos_z,
  input  wire logic [7:0]  in_red_in,
  input  wire logic [7:0]  in_green_in,
  input  wire logic [7:0]  in_blue_in,
  input  wire logic [7:0]  in_intensity,
  input  wire logic [7:0]  in_class_code,
  input  wire logic        in_rgb_present,
  input  wire logic        in_keep,
  // result channel
  output logic             out_valid,
  output logic [31:0]      out_index,
  output logic [14:0]      out_cell_index,
  output logic [7:0]       out_red_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_blue_out,
  // config port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // grid value and cell coordinate width
  localparam int GW = $clog2(MAX_GRID + 1);
  // width of y+g*z and of the full linear index
  localparam int TW = 2 * GW;
  localparam int LW = (3 * GW > pgb_pkg::CELL_W) ? 3 * GW : pgb_pkg::CELL_W;
  localparam int NST = 5;

  // config registers
  logic [31:0] min_x_r, min_y_r, min_z_r;
  logic [31:0] scale_x_r, scale_y_r, scale_z_r;
  logic [5:0]  grid_size_r;
  logic [1:0]  colour_mode_r;

  logic busy_r;
  logic accept;

  // pipe control and side data
  logic [NST-1:0]  v_r;
  pgb_pkg::meta_t  meta_r [NST];
  pgb_pkg::meta_t  meta_nxt;

  // effective grid size
  logic [6:0]    g_full;
  logic [GW-1:0] g_w;
  logic [GW-1:0] gm1;

  // axis results (stage 3)
  logic [GW-1:0] cx, cy, cz;
  logic [GW-1:0] cx_d_r;
  logic [TW-1:0] t_r;
  logic [LW-1:0] cell_r;

  // colour selection
  logic [1:0]     mode_eff;
  pgb_pkg::rgb_t  colour_nxt;

  pgb_pkg::axis_op_t op_x, op_y, op_z;

  // ---------------------------------------------------------------------------
  // config writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r       <= 32'd0;
      min_y_r       <= 32'd0;
      min_z_r       <= 32'd0;
      scale_x_r     <= 32'd65536;
      scale_y_r     <= 32'd65536;
      scale_z_r     <= 32'd65536;
      grid_size_r   <= 6'd1;
      colour_mode_r <= pgb_pkg::MODE_AUTO;
    end else if (cfg_we) begin
      case (cfg_index)
        pgb_pkg::REG_MIN_X:   min_x_r       <= cfg_data;
        pgb_pkg::REG_MIN_Y:   min_y_r       <= cfg_data;
        pgb_pkg::REG_MIN_Z:   min_z_r       <= cfg_data;
        pgb_pkg::REG_SCALE_X: scale_x_r     <= cfg_data;
        pgb_pkg::REG_SCALE_Y: scale_y_r     <= cfg_data;
        pgb_pkg::REG_SCALE_Z: scale_z_r     <= cfg_data;
        pgb_pkg::REG_GRID:    grid_size_r   <= cfg_data[5:0];
        pgb_pkg::REG_MODE:    colour_mode_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: the pipe never blocks, busy only covers the cycle after reset
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // ---------------------------------------------------------------------------
  // grid size: zero reads as one, large values saturate
  // ---------------------------------------------------------------------------
  always_comb begin
    if (grid_size_r == 6'd0) begin
      g_full = 7'd1;
    end else if ({1'b0, grid_size_r} > 7'(MAX_GRID)) begin
      g_full = 7'(MAX_GRID);
    end else begin
      g_full = {1'b0, grid_size_r};
    end
  end

  assign g_w = g_full[GW-1:0];
  assign gm1 = g_w - GW'(1);

  // ---------------------------------------------------------------------------
  // colour choice, done on entry and carried with the point
  // ---------------------------------------------------------------------------
  always_comb begin
    mode_eff = colour_mode_r;
    if (colour_mode_r == pgb_pkg::MODE_AUTO) begin
      mode_eff = in_rgb_present ? pgb_pkg::MODE_RGB : pgb_pkg::MODE_GREY;
    end
    colour_nxt = pgb_pkg::WHITE;
    case (mode_eff)
      pgb_pkg::MODE_RGB: begin
        if (in_rgb_present) begin
          colour_nxt = '{r: in_red_in, g: in_green_in, b: in_blue_in};
        end else begin
          // rgb asked for but absent: grey from intensity
          colour_nxt = '{r: in_intensity, g: in_intensity, b: in_intensity};
        end
      end
      pgb_pkg::MODE_GREY: begin
        colour_nxt = '{r: in_intensity, g: in_intensity, b: in_intensity};
      end
      pgb_pkg::MODE_CLASS: begin
        // class beyond the palette stays white
        if (({1'b0, in_class_code} < 9'(pgb_pkg::PALETTE_ENTRIES)) &&
            ({1'b0, in_class_code} < 9'(pgb_pkg::PAL_TABLE_SIZE))) begin
          colour_nxt = pgb_pkg::palette_rgb(in_class_code[3:0]);
        end
      end
      default: colour_nxt = pgb_pkg::WHITE;
    endcase
    meta_nxt = '{index: in_point_index, colour: colour_nxt};
  end

  // ---------------------------------------------------------------------------
  // axis units: stages 1 to 3
  // ---------------------------------------------------------------------------
  assign op_x = '{pos: in_pos_x, minv: min_x_r, scale: scale_x_r};
  assign op_y = '{pos: in_pos_y, minv: min_y_r, scale: scale_y_r};
  assign op_z = '{pos: in_pos_z, minv: min_z_r, scale: scale_z_r};

  pgb_axis #(.GW(GW)) u_axis_x (.clk(clk), .op(op_x), .gm1(gm1), .coord(cx));
  pgb_axis #(.GW(GW)) u_axis_y (.clk(clk), .op(op_y), .gm1(gm1), .coord(cy));
  pgb_axis #(.GW(GW)) u_axis_z (.clk(clk), .op(op_z), .gm1(gm1), .coord(cz));

  // ---------------------------------------------------------------------------
  // stage 4: t = y + g*z; stage 5: cell = x + g*t
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    cx_d_r <= cx;
    t_r    <= TW'(cy) + TW'(g_w) * TW'(cz);
    cell_r <= LW'(cx_d_r) + LW'(g_w) * LW'(t_r);
  end

  // valid bits; dropped points never enter the pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[NST-2:0], accept && in_keep};
    end
  end

  always_ff @(posedge clk) begin
    meta_r[0] <= meta_nxt;
    for (int i = 1; i < NST; i++) begin
      meta_r[i] <= meta_r[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // result beat
  // ---------------------------------------------------------------------------
  assign out_valid      = v_r[NST-1];
  assign out_index      = meta_r[NST-1].index;
  assign out_cell_index = cell_r[pgb_pkg::CELL_W-1:0];
  assign out_red_out    = meta_r[NST-1].colour.r;
  assign out_green_out  = meta_r[NST-1].colour.g;
  assign out_blue_out   = meta_r[NST-1].colour.b;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
`include "point_grid_bin_and_colour_core_macros.svh"

  // a result beat always traces back to an accepted kept point
  `PGB_ASSERT_IMP(a_out_from_kept, out_valid, $past(start && !busy && in_keep, 5))
  // the index travels with its point
  `PGB_ASSERT_IMP(a_index_aligned, out_valid, out_index == $past(in_point_index, 5))
  // a kept point with no reset in between always comes out
  `PGB_ASSERT_IMP(a_kept_delivered, $past(start && !busy && in_keep, 5) && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4) && $past(rst_n, 5), out_valid)
  // a dropped point leaves no trace in the pipe
  `PGB_ASSERT_NXT(a_drop_empty, start && !busy && !in_keep, !v_r[0])

endmodule

`default_nettype wire

[test/point_grid_bin_and_colour_core_test.sv]
// ----------------------------------------------------------------------------
// point_grid_bin_and_colour_core_test
// self-checking bench for the grid binning and colour core: a queue-fed
// driver sends point beats steady or in random bursts, a predictor computes the cell
// and colour of every kept point, and a monitor checks each result beat
// ----------------------------------------------------------------------------
`default_nettype none

module point_grid_bin_and_colour_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // pipe depth from the accepting edge to the end of the result cycle
  localparam int LATENCY = 5;

  // one point as the driver sends it
  typedef struct packed {
    logic [31:0] index;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  intensity;
    logic [7:0]  class_code;
    logic        rgb_present;
    logic        keep;
  } point_t;

  // one binned point as the block should return it
  typedef struct packed {
    logic [31:0] index;
    logic [14:0] cell_idx;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } bin_t;

  // bench copy of the register file
  typedef struct packed {
    logic [31:0] min_x;
    logic [31:0] min_y;
    logic [31:0] min_z;
    logic [31:0] scale_x;
    logic [31:0] scale_y;
    logic [31:0] scale_z;
    logic [5:0]  grid_size;
    logic [1:0]  colour_mode;
  } box_regs_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_point_index = '0;
  logic [31:0] in_pos_x = '0;
  logic [31:0] in_pos_y = '0;
  logic [31:0] in_pos_z = '0;
  logic [7:0]  in_red_in = '0;
  logic [7:0]  in_green_in = '0;
  logic [7:0]  in_blue_in = '0;
  logic [7:0]  in_intensity = '0;
  logic [7:0]  in_class_code = '0;
  logic        in_rgb_present = 1'b0;
  logic        in_keep = 1'b0;
  logic        out_valid;
  logic [31:0] out_index;
  logic [14:0] out_cell_index;
  logic [7:0]  out_red_out;
  logic [7:0]  out_green_out;
  logic [7:0]  out_blue_out;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  point_grid_bin_and_colour_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_point_index (in_point_index),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .in_intensity   (in_intensity),
    .in_class_code  (in_class_code),
    .in_rgb_present (in_rgb_present),
    .in_keep        (in_keep),
    .out_valid      (out_valid),
    .out_index      (out_index),
    .out_cell_index (out_cell_index),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // points waiting for the driver, and bins waiting for their result beat
  point_t      pending_points[$];
  bin_t        expected_bins[$];
  box_regs_t   model_regs;
  point_t      cur_point;
  logic        taken = 1'b0;
  int          mismatch_count = 0;

  // sender burst shaping, retuned by the stimulus per phase
  bit          bursts_on = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;

  // box extents (Q16.16) that random positions are spread around
  int unsigned span_x = 32'h0001_0000;
  int unsigned span_y = 32'h0001_0000;
  int unsigned span_z = 32'h0001_0000;

  initial begin
    forever #6 clk = ~clk;
  end

  // hard stop in case the pipe hangs or drops a beat
  initial begin
    #2_000_000;
    $display("** point_grid_bin_and_colour_core: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // exact 33-bit difference, Q32.32 product, truncate then clamp to g-1
  function automatic int unsigned axis_cell(input logic [31:0] pos,
                                            input logic [31:0] minv,
                                            input logic [31:0] scale,
                                            input int unsigned g);
    logic signed [32:0] diff;
    logic [63:0]        prod;
    diff = $signed({pos[31], pos}) - $signed({minv[31], minv});
    if (diff <= 0) return 0;
    prod = {32'd0, diff[31:0]} * {32'd0, scale};
    if (prod[63:32] > g - 1) return g - 1;
    return prod[63:32];
  endfunction

  function automatic bin_t predict_bin(input point_t p);
    bin_t        b;
    int unsigned g;
    int unsigned cx;
    int unsigned cy;
    int unsigned cz;
    int unsigned lin;
    logic [1:0]  mode;
    logic [23:0] rgb;
    g = model_regs.grid_size;
    if (g == 0) g = 1;
    if (g > pgb_pkg::MAX_GRID_DEF) g = pgb_pkg::MAX_GRID_DEF;
    cx = axis_cell(p.pos_x, model_regs.min_x, model_regs.scale_x, g);
    cy = axis_cell(p.pos_y, model_regs.min_y, model_regs.scale_y, g);
    cz = axis_cell(p.pos_z, model_regs.min_z, model_regs.scale_z, g);
    lin = cx + g * (cy + g * cz);

    // auto picks rgb when the source has it, grey otherwise
    mode = model_regs.colour_mode;
    if (mode == pgb_pkg::MODE_AUTO) begin
      mode = p.rgb_present ? pgb_pkg::MODE_RGB : pgb_pkg::MODE_GREY;
    end
    rgb = 24'hFF_FFFF;
    case (mode)
      pgb_pkg::MODE_RGB: begin
        // rgb mode on a point without colour falls back to grey
        rgb = p.rgb_present ? {p.red, p.green, p.blue} : {3{p.intensity}};
      end
      pgb_pkg::MODE_GREY: begin
        rgb = {3{p.intensity}};
      end
      pgb_pkg::MODE_CLASS: begin
        // palette fractions rounded to 8 bits, white past the last entry
        if (p.class_code < pgb_pkg::PALETTE_ENTRIES) begin
          case (p.class_code[3:0])
            4'd0:    rgb = {8'd128, 8'd128, 8'd128};
            4'd1:    rgb = {8'd179, 8'd179, 8'd179};
            4'd2:    rgb = {8'd153, 8'd102, 8'd51};
            4'd3:    rgb = {8'd140, 8'd204, 8'd77};
            4'd4:    rgb = {8'd64,  8'd166, 8'd26};
            4'd5:    rgb = {8'd0,   8'd115, 8'd13};
            4'd6:    rgb = {8'd230, 8'd191, 8'd26};
            4'd7:    rgb = {8'd204, 8'd26,  8'd26};
            4'd8:    rgb = {8'd77,  8'd77,  8'd230};
            4'd9:    rgb = {8'd0,   8'd140, 8'd255};
            4'd10:   rgb = {8'd217, 8'd217, 8'd217};
            4'd11:   rgb = {8'd242, 8'd140, 8'd38};
            4'd12:   rgb = {8'd179, 8'd0,   8'd179};
            4'd13:   rgb = {8'd255, 8'd51,  8'd204};
            4'd14:   rgb = {8'd255, 8'd153, 8'd0};
            default: rgb = {8'd0,   8'd230, 8'd230};
          endcase
        end
      end
      default: ;
    endcase

    b.index    = p.index;
    b.cell_idx = lin[14:0];
    b.red      = rgb[23:16];
    b.green    = rgb[15:8];
    b.blue     = rgb[7:0];
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one point beat per accept, steady or in bursts with random gaps
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (start && !taken) begin
      // beat still waiting for busy to drop, hold everything
    end else if (rst_n && gap_left == 0 && pending_points.size() != 0) begin
      cur_point = pending_points.pop_front();
      in_point_index <= cur_point.index;
      in_pos_x       <= cur_point.pos_x;
      in_pos_y       <= cur_point.pos_y;
      in_pos_z       <= cur_point.pos_z;
      in_red_in      <= cur_point.red;
      in_green_in    <= cur_point.green;
      in_blue_in     <= cur_point.blue;
      in_intensity   <= cur_point.intensity;
      in_class_code  <= cur_point.class_code;
      in_rgb_present <= cur_point.rgb_present;
      in_keep        <= cur_point.keep;
      start          <= 1'b1;
      if (bursts_on) begin
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end
    end else begin
      if (gap_left > 0) gap_left--;
      start <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check result beats, predict on each accepted kept point
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    bin_t want;
    taken <= rst_n && start && !busy;
    if (rst_n && out_valid) begin
      if (expected_bins.size() == 0) begin
        $error("result beat with no point waiting: index %0h", out_index);
        mismatch_count++;
      end else begin
        want = expected_bins.pop_front();
        check_field("out_index", want.index, out_index);
        check_field("out_cell_index", 32'(want.cell_idx), 32'(out_cell_index));
        check_field("out_red_out", 32'(want.red), 32'(out_red_out));
        check_field("out_green_out", 32'(want.green), 32'(out_green_out));
        check_field("out_blue_out", 32'(want.blue), 32'(out_blue_out));
      end
    end
    // dropped points leave nothing to wait for
    if (rst_n && start && !busy && cur_point.keep)
      expected_bins.insert(expected_bins.size(), predict_bin(cur_point));
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // hand one point to the driver, in order
  task automatic enqueue_point(input point_t p);
    pending_points.insert(pending_points.size(), p);
  endtask

  // position spread a little past both ends of the box on one axis
  function automatic logic [31:0] near_box(input logic [31:0] minv,
                                           input int unsigned span);
    longint off;
    off = $urandom_range(0, span + span / 4);
    off = off - span / 8;
    return minv + off[31:0];
  endfunction

  function automatic point_t rand_point();
    point_t p;
    p.index       = $urandom;
    p.red         = 8'($urandom);
    p.green       = 8'($urandom);
    p.blue        = 8'($urandom);
    p.intensity   = 8'($urandom);
    p.class_code  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 17));
    p.rgb_present = 1'($urandom_range(0, 1));
    p.keep        = ($urandom_range(0, 7) != 0);
    if ($urandom_range(0, 6) == 0) begin
      // raw noise so every position bit toggles
      p.pos_x = $urandom;
      p.pos_y = $urandom;
      p.pos_z = $urandom;
    end else begin
      p.pos_x = near_box(model_regs.min_x, span_x);
      p.pos_y = near_box(model_regs.min_y, span_y);
      p.pos_z = near_box(model_regs.min_z, span_z);
    end
    return p;
  endfunction

  // extent of 1..2000 units, scale = g / extent, minimum within +-30000 units
  task automatic pick_axis(input int unsigned g, output logic [31:0] minv,
                           output logic [31:0] scale, output int unsigned span);
    int unsigned units;
    int          m;
    units = $urandom_range(1, 2000);
    span  = units << 16;
    scale = (g << 16) / units;
    m     = $urandom_range(0, 60000);
    m     = m - 30000;
    minv  = m << 16;
  endtask

  task automatic choose_box(input int ph, output box_regs_t r);
    int unsigned g;
    g = $urandom_range(1, pgb_pkg::MAX_GRID_DEF);
    case (ph)
      0, 3:    g = pgb_pkg::MAX_GRID_DEF;
      1, 2:    g = 1;
      default: ;
    endcase
    pick_axis(g, r.min_x, r.scale_x, span_x);
    pick_axis(g, r.min_y, r.scale_y, span_y);
    pick_axis(g, r.min_z, r.scale_z, span_z);
    r.grid_size = g[5:0];
    case (ph)
      0: r.colour_mode = pgb_pkg::MODE_AUTO;
      1: r.colour_mode = pgb_pkg::MODE_RGB;
      2: begin
        // size field zero acts as a single cell
        r.grid_size   = 6'd0;
        r.colour_mode = pgb_pkg::MODE_GREY;
      end
      3: begin
        // oversized grid saturates, scale extremes on x and y
        r.grid_size   = 6'd63;
        r.scale_x     = 32'h0000_0000;
        r.scale_y     = 32'hFFFF_FFFF;
        r.colour_mode = pgb_pkg::MODE_CLASS;
      end
      4: begin
        r.min_x       = 32'h8000_0000;
        r.min_y       = 32'h7FFF_FFFF;
        r.colour_mode = pgb_pkg::MODE_AUTO;
      end
      5:       r.colour_mode = pgb_pkg::MODE_RGB;
      default: r.colour_mode = pgb_pkg::MODE_CLASS;
    endcase
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  // every register on each reprogram, only while the pipe is empty
  task automatic program_regs(input box_regs_t r);
    write_reg(pgb_pkg::REG_MIN_X, r.min_x);
    write_reg(pgb_pkg::REG_MIN_Y, r.min_y);
    write_reg(pgb_pkg::REG_MIN_Z, r.min_z);
    write_reg(pgb_pkg::REG_SCALE_X, r.scale_x);
    write_reg(pgb_pkg::REG_SCALE_Y, r.scale_y);
    write_reg(pgb_pkg::REG_SCALE_Z, r.scale_z);
    write_reg(pgb_pkg::REG_GRID, {26'd0, r.grid_size});
    write_reg(pgb_pkg::REG_MODE, {30'd0, r.colour_mode});
    @(negedge clk);
    cfg_we     <= 1'b0;
    model_regs = r;
  endtask

  // sender idle and every bin back, then let dropped points clear the pipe
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_points.size() != 0 || start || expected_bins.size() != 0);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    box_regs_t cfg;
    point_t    p;
    int        classes[4];

    // register defaults after reset
    model_regs.min_x       = '0;
    model_regs.min_y       = '0;
    model_regs.min_z       = '0;
    model_regs.scale_x     = 32'h0001_0000;
    model_regs.scale_y     = 32'h0001_0000;
    model_regs.scale_z     = 32'h0001_0000;
    model_regs.grid_size   = 6'd1;
    model_regs.colour_mode = pgb_pkg::MODE_AUTO;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: dropped point, auto to rgb, auto to grey
    p = rand_point();
    p.keep = 1'b0;
    enqueue_point(p);
    p = rand_point();
    p.keep = 1'b1;
    p.rgb_present = 1'b1;
    p.pos_x = 32'hFFFF_FFFF;
    p.pos_y = 32'hFFFF_FFFF;
    p.pos_z = 32'hFFFF_FFFF;
    enqueue_point(p);
    p = rand_point();
    p.keep = 1'b1;
    p.rgb_present = 1'b0;
    p.pos_x = 32'h7FFF_FFFF;
    p.pos_y = 32'h7FFF_FFFF;
    p.pos_z = 32'h7FFF_FFFF;
    enqueue_point(p);
    wait_drained();

    // full grid, unit scale, palette: in-range, last, and past-end classes
    cfg.min_x = '0;
    cfg.min_y = '0;
    cfg.min_z = '0;
    cfg.scale_x = 32'h0001_0000;
    cfg.scale_y = 32'h0001_0000;
    cfg.scale_z = 32'h0001_0000;
    cfg.grid_size = 6'd32;
    cfg.colour_mode = pgb_pkg::MODE_CLASS;
    program_regs(cfg);
    span_x = 32 << 16;
    span_y = 32 << 16;
    span_z = 32 << 16;
    classes = '{0, 15, 16, 255};
    foreach (classes[i]) begin
      p = rand_point();
      p.keep = 1'b1;
      p.class_code = 8'(classes[i]);
      p.pos_x = 32'h0005_8000;
      p.pos_y = 32'h001F_FFFF;
      p.pos_z = 32'h0028_0000;
      enqueue_point(p);
    end
    p = rand_point();
    p.keep = 1'b1;
    p.class_code = 8'd7;
    p.pos_x = 32'h8000_0000;
    p.pos_y = 32'h7FFF_FFFF;
    p.pos_z = 32'h0000_0000;
    enqueue_point(p);
    wait_drained();

    // zero scale and zero grid size, rgb mode with and without colour
    cfg.scale_x = '0;
    cfg.scale_y = '0;
    cfg.scale_z = '0;
    cfg.grid_size = 6'd0;
    cfg.colour_mode = pgb_pkg::MODE_RGB;
    program_regs(cfg);
    for (int i = 0; i < 2; i++) begin
      p = rand_point();
      p.keep = 1'b1;
      p.rgb_present = i[0];
      p.pos_x = 32'h7FFF_FFFF;
      p.pos_y = 32'h7FFF_FFFF;
      p.pos_z = 32'h7FFF_FFFF;
      enqueue_point(p);
    end
    wait_drained();

    // extreme minimums and scales, oversized grid, grey mode
    cfg.min_x = 32'h8000_0000;
    cfg.min_y = 32'h7FFF_FFFF;
    cfg.min_z = '0;
    cfg.scale_x = 32'hFFFF_FFFF;
    cfg.scale_y = 32'hFFFF_FFFF;
    cfg.scale_z = 32'h0001_0000;
    cfg.grid_size = 6'd63;
    cfg.colour_mode = pgb_pkg::MODE_GREY;
    program_regs(cfg);
    p = rand_point();
    p.keep = 1'b1;
    p.pos_x = 32'h7FFF_FFFF;
    p.pos_y = 32'h8000_0000;
    p.pos_z = 32'h0064_0000;
    enqueue_point(p);
    p = rand_point();
    p.keep = 1'b1;
    p.pos_x = 32'h8000_0000;
    p.pos_y = 32'h7FFF_FFFF;
    p.pos_z = 32'h7FFF_FFFF;
    enqueue_point(p);
    p = rand_point();
    p.keep = 1'b1;
    p.pos_x = 32'h8000_0001;
    p.pos_y = 32'h0000_0000;
    p.pos_z = 32'h8000_0000;
    enqueue_point(p);
    wait_drained();

    // random phases, one box per phase, bursty sender except phase five
    for (int ph = 0; ph < 7; ph++) begin
      choose_box(ph, cfg);
      program_regs(cfg);
      bursts_on  = (ph != 5);
      burst_left = 0;
      gap_left   = 0;
      if (ph == 5) begin
        // full rate, with the sender parked until every bin is back
        repeat (50) enqueue_point(rand_point());
        wait_drained();
        repeat (50) enqueue_point(rand_point());
      end else begin
        repeat (100) enqueue_point(rand_point());
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("** point_grid_bin_and_colour_core: PASSED **");
    end else begin
      $display("** point_grid_bin_and_colour_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
+incdir+src
src/pgb_pkg.sv
src/pgb_axis.sv
src/point_grid_bin_and_colour_core.sv
test/point_grid_bin_and_colour_core_test.sv
